// File: hdl/i2cw_pkg.sv
// Shared types and constants of the three-byte I2C write master.
`default_nettype none

package i2cw_pkg;

    localparam int FRAME_BYTES = 3;

    localparam int REG_INDEX_W = 2;
    localparam int REG_DATA_W  = 8;

    localparam logic [REG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_WORD_ADDRESS   = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_DATA_BYTE      = 2'd2;

    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'hA0;
    localparam logic [7:0] WORD_ADDRESS_RST   = 8'h71;
    localparam logic [7:0] DATA_BYTE_RST      = 8'h51;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] word_address;
        logic [7:0] device_address;
    } t_frame;

    // Declared from the highest bit down, so scl_level sits in bit 0.
    typedef struct packed {
        logic frame_done;
        logic busy_res;
        logic ack_led;
        logic sda_enable;
        logic sda_level;
        logic scl_level;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/i2cw_cfg_regs.sv
// Configuration registers holding the three bytes of the frame.
`default_nettype none

module i2cw_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [i2cw_pkg::REG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [i2cw_pkg::REG_DATA_W-1:0]   i_cfg_data,
    output i2cw_pkg::t_frame                       o_frame
);

    i2cw_pkg::t_frame r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame.device_address <= i2cw_pkg::DEVICE_ADDRESS_RST;
            r_frame.word_address   <= i2cw_pkg::WORD_ADDRESS_RST;
            r_frame.data_byte      <= i2cw_pkg::DATA_BYTE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                i2cw_pkg::REG_DEVICE_ADDRESS: r_frame.device_address <= i_cfg_data;
                i2cw_pkg::REG_WORD_ADDRESS:   r_frame.word_address   <= i_cfg_data;
                i2cw_pkg::REG_DATA_BYTE:      r_frame.data_byte      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_frame = r_frame;

endmodule

`default_nettype wire

// File: hdl/i2cw_seq.sv
// Bus sequencer: phase machine and bit shifter, one bus tick per advance.
`default_nettype none

module i2cw_seq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    input  wire logic        i_go,
    input  wire logic        i_sda_in,
    input  wire i2cw_pkg::t_frame i_frame,
    output i2cw_pkg::t_result o_result
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START_LOW = 4'd1;
    localparam logic [3:0] PH_BIT_LOW   = 4'd2;
    localparam logic [3:0] PH_BIT_HIGH  = 4'd3;
    localparam logic [3:0] PH_ACK_LOW   = 4'd4;
    localparam logic [3:0] PH_ACK_HIGH  = 4'd5;
    localparam logic [3:0] PH_STOP_LOW  = 4'd6;
    localparam logic [3:0] PH_STOP_HIGH = 4'd7;
    localparam logic [3:0] PH_STOP_RISE = 4'd8;

    localparam logic [1:0] LAST_BYTE = 2'(i2cw_pkg::FRAME_BYTES - 1);

    logic [3:0] r_phase,      n_phase;
    logic [2:0] r_bit_count,  n_bit_count;
    logic [1:0] r_byte_index, n_byte_index;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic       r_ack_seen,   n_ack_seen;

    logic [1:0] next_index;
    logic [7:0] next_byte;
    i2cw_pkg::t_result res;

    always_comb begin
        next_index = r_byte_index + 2'd1;
        case (next_index)
            2'd1:    next_byte = i_frame.word_address;
            default: next_byte = i_frame.data_byte;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_byte_index = r_byte_index;
        n_shift_byte = r_shift_byte;
        n_ack_seen   = r_ack_seen;

        res            = '0;
        res.scl_level  = 1'b1;
        res.sda_level  = 1'b1;
        res.sda_enable = 1'b1;
        res.busy_res   = 1'b1;

        unique case (r_phase)
            PH_START_LOW: begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
                n_phase       = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
                res.scl_level = 1'b0;
                res.sda_level = r_shift_byte[7];
                n_phase       = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
                res.sda_level = r_shift_byte[7];
                n_shift_byte  = {r_shift_byte[6:0], 1'b0};
                if (r_bit_count == 3'd7) begin
                    n_bit_count = 3'd0;
                    n_phase     = PH_ACK_LOW;
                end else begin
                    n_bit_count = r_bit_count + 3'd1;
                    n_phase     = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW: begin
                res.scl_level  = 1'b0;
                res.sda_enable = 1'b0;
                n_phase        = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                res.sda_enable = 1'b0;
                n_ack_seen     = ~i_sda_in;
                if (r_byte_index >= LAST_BYTE) begin
                    n_phase = PH_STOP_LOW;
                end else begin
                    n_byte_index = next_index;
                    n_shift_byte = next_byte;
                    n_bit_count  = 3'd0;
                    n_phase      = PH_BIT_LOW;
                end
            end
            PH_STOP_LOW: begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
                n_phase       = PH_STOP_HIGH;
            end
            PH_STOP_HIGH: begin
                res.sda_level = 1'b0;
                n_phase       = PH_STOP_RISE;
            end
            PH_STOP_RISE: begin
                res.frame_done = 1'b1;
                n_phase        = PH_IDLE;
                n_byte_index   = 2'd0;
                n_bit_count    = 3'd0;
            end
            default: begin
                if (i_go) begin
                    res.sda_level = 1'b0;
                    n_byte_index  = 2'd0;
                    n_bit_count   = 3'd0;
                    n_shift_byte  = i_frame.device_address;
                    n_phase       = PH_START_LOW;
                end else begin
                    res.busy_res = 1'b0;
                    n_phase      = PH_IDLE;
                end
            end
        endcase

        res.ack_led = n_ack_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 3'd0;
            r_byte_index <= 2'd0;
            r_shift_byte <= 8'd0;
            r_ack_seen   <= 1'b0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_byte_index <= n_byte_index;
            r_shift_byte <= n_shift_byte;
            r_ack_seen   <= n_ack_seen;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// File: hdl/i2c_three_byte_write_master.sv
// Top level of the three-byte I2C write master.
// Each input beat is one bus tick and yields exactly one output beat in the cycle
// after it is accepted. A beat can be accepted in every cycle: the phase machine
// advances one tick per beat and the result lands in an output register, so the
// sustained rate is one tick per clock while the output side keeps taking beats.
// A frame lasts 59 ticks: two for the start, two per bit, two per acknowledge and
// three for the stop. The frame bytes are read from the configuration registers
// when each byte begins.
`default_nettype none

module i2c_three_byte_write_master (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [i2cw_pkg::REG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [i2cw_pkg::REG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Bit 0 go, bit 1 sda_in, upper bits zero.
    input  wire logic [i2cw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // Bit 0 scl_level, 1 sda_level, 2 sda_enable, 3 ack_led, 4 busy_res,
    // 5 frame_done, upper bits zero.
    output logic [i2cw_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

    i2cw_pkg::t_frame  frame;
    i2cw_pkg::t_result result;

    logic              accept;
    logic              r_out_valid;
    i2cw_pkg::t_result r_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    i2cw_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_frame     (frame)
    );

    i2cw_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_go      (s_axis_tdata[0]),
        .i_sda_in  (s_axis_tdata[1]),
        .i_frame   (frame),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(i2cw_pkg::M_TDATA_W - $bits(i2cw_pkg::t_result))'(0), r_out};

endmodule

`default_nettype wire
